[hw/rtl/sseg_pkg.sv]
// Shared types, codes and lookup tables of the seven-segment display formatter.
package sseg_pkg;

   // Request kinds.
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_VALUE = 2'd1;
   localparam logic [1:0] KIND_MODE  = 2'd2;
   localparam logic [1:0] KIND_TEXT  = 2'd3;

   // Display symbol codes.
   typedef logic [4:0] sym_type;
   localparam sym_type SYM_BLANK = 5'd10;
   localparam sym_type SYM_A     = 5'd11;
   localparam sym_type SYM_SEP   = 5'd27;
   localparam sym_type SYM_MAX   = 5'd27;

   // Number of known mode words.
   localparam logic [2:0] MODE_WORDS = 3'd5;

   // Hold length after reset, in ticks.
   localparam logic [11:0] HOLD_RESET = 12'd1500;

   // Segment drive with every segment dark.
   localparam logic [6:0] SEG_DARK = 7'h7F;

   // Buffer of four symbols, entry 0 is the leftmost digit.
   typedef sym_type [3:0] symbols_type;

   // A registered request, with the value already clamped at zero.
   typedef struct packed {
      logic [1:0]       kind;
      logic [14:0]      mag;
      logic             work_screen;
      logic [3:0]       menu_item;
      logic [2:0]       mode_number;
      logic [3:0][7:0]  text;
   } item_type;

   // Quotients of the clamped value by 10, 100, 1000 and 10000.
   typedef struct packed {
      logic [11:0] q1;
      logic [8:0]  q2;
      logic [5:0]  q3;
      logic [1:0]  q4;
   } quot_type;

   // Segment pattern of a symbol; a zero bit lights the segment.
   function automatic logic [6:0] glyph(input sym_type s);
      logic [7:0] g;
      unique case (s)
         5'd0:  g = 8'hC0;
         5'd1:  g = 8'hF9;
         5'd2:  g = 8'hA4;
         5'd3:  g = 8'hB0;
         5'd4:  g = 8'h99;
         5'd5:  g = 8'h92;
         5'd6:  g = 8'h82;
         5'd7:  g = 8'hF8;
         5'd8:  g = 8'h80;
         5'd9:  g = 8'h90;
         5'd10: g = 8'hFF;
         5'd11: g = 8'h88;
         5'd12: g = 8'h8E;
         5'd13: g = 8'h86;
         5'd14: g = 8'h92;
         5'd15: g = 8'hC2;
         5'd16: g = 8'hC1;
         5'd17: g = 8'hAF;
         5'd18: g = 8'hAB;
         5'd19: g = 8'h87;
         5'd20: g = 8'h8C;
         5'd21: g = 8'h98;
         5'd22: g = 8'hA7;
         5'd23: g = 8'hA1;
         5'd24: g = 8'hC7;
         5'd25: g = 8'hA3;
         5'd26: g = 8'h83;
         5'd27: g = 8'hA7;
         default: g = 8'hFF;
      endcase
      return g[6:0];
   endfunction

   // Fixed mode words: FEr, SS, coLd, SPot, ALu.
   function automatic symbols_type mode_word(input logic [2:0] mode);
      symbols_type w;
      unique case (mode)
         3'd0:    w = {SYM_BLANK, 5'd17, 5'd13, 5'd12};
         3'd1:    w = {SYM_BLANK, SYM_BLANK, 5'd14, 5'd14};
         3'd2:    w = {5'd23, 5'd24, 5'd25, 5'd22};
         3'd3:    w = {5'd19, 5'd25, 5'd20, 5'd14};
         3'd4:    w = {SYM_BLANK, 5'd16, 5'd24, SYM_A};
         default: w = {SYM_BLANK, SYM_BLANK, SYM_BLANK, SYM_BLANK};
      endcase
      return w;
   endfunction

   // ASCII character to symbol; characters without a glyph show blank.
   function automatic sym_type char_symbol(input logic [7:0] c);
      sym_type s;
      if (c >= 8'h30 && c <= 8'h39) begin
         s = 5'(c - 8'h30);
      end else begin
         unique case (c)
            8'h41:                      s = SYM_A;
            8'h46:                      s = 5'd12;
            8'h45:                      s = 5'd13;
            8'h53, 8'h73:               s = 5'd14;
            8'h47:                      s = 5'd15;
            8'h75, 8'h55, 8'h76, 8'h56: s = 5'd16;
            8'h72:                      s = 5'd17;
            8'h6E:                      s = 5'd18;
            8'h74:                      s = 5'd19;
            8'h50:                      s = 5'd20;
            8'h71:                      s = 5'd21;
            8'h63, 8'h43:               s = 5'd22;
            8'h64:                      s = 5'd23;
            8'h4C:                      s = 5'd24;
            8'h6F:                      s = 5'd25;
            8'h62:                      s = 5'd26;
            default:                    s = SYM_BLANK;
         endcase
      end
      return s;
   endfunction

   // Decimal digit of hi, given next = hi / 10.
   function automatic sym_type digit_of(input logic [14:0] hi, input logic [11:0] next);
      logic [14:0] rem;
      rem = hi - 15'(next) * 15'd10;
      return {1'b0, rem[3:0]};
   endfunction

endpackage

[hw/rtl/sseg_channels.sv]
// Request, response and register write channels of the display formatter.
interface sseg_req_if;
   logic             valid;
   logic             ready;
   logic [1:0]       kind;
   logic signed [15:0] value;
   logic             work_screen;
   logic [3:0]       menu_item;
   logic [2:0]       mode_number;
   logic [7:0]       text_char_0;
   logic [7:0]       text_char_1;
   logic [7:0]       text_char_2;
   logic [7:0]       text_char_3;

   modport source (
      output valid, kind, value, work_screen, menu_item, mode_number,
             text_char_0, text_char_1, text_char_2, text_char_3,
      input  ready
   );
   modport sink (
      input  valid, kind, value, work_screen, menu_item, mode_number,
             text_char_0, text_char_1, text_char_2, text_char_3,
      output ready
   );
endinterface

interface sseg_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] segments;
   logic [3:0] anode_enable;
   logic       update_ignored;

   modport source (output valid, segments, anode_enable, update_ignored, input ready);
   modport sink (input valid, segments, anode_enable, update_ignored, output ready);
endinterface

interface sseg_csr_if;
   logic        valid;
   logic        ready;
   logic [11:0] hold_ms;

   modport source (output valid, hold_ms, input ready);
   modport sink (input valid, hold_ms, output ready);
endinterface

[hw/rtl/sseg_divide.sv]
// Decimal quotients of a 15-bit value by reciprocal multiplication.
module sseg_divide
   import sseg_pkg::*;
(
   input  logic [14:0] mag,
   output quot_type    quot
);

   logic [31:0] prod_10;
   logic [31:0] prod_100;
   logic [31:0] prod_1000;
   logic [31:0] prod_10000;

   // Each reciprocal is exact for every value below 32768.
   assign prod_10    = 32'(mag) * 32'd52429;
   assign prod_100   = 32'(mag) * 32'd5243;
   assign prod_1000  = 32'(mag) * 32'd67109;
   assign prod_10000 = 32'(mag) * 32'd13422;

   assign quot.q1 = prod_10[30:19];
   assign quot.q2 = prod_100[27:19];
   assign quot.q3 = prod_1000[31:26];
   assign quot.q4 = prod_10000[28:27];

endmodule

[hw/rtl/seven_segment_mux_display_formatter.sv]
// Top level of the multiplexed four-digit seven-segment display formatter.
//
// The block takes one request per clock and returns one response for each
// from its response register. The first stage registers the request with the
// value clamped at zero and its quotients by 10, 100, 1000 and 10000 (one
// reciprocal multiplier each); the second stage applies the request to the
// symbol buffer, scan position and hold counter and loads the response
// register. Throughput is one request per cycle and is limited only by the
// response side taking results. A tick request scans the next digit; the
// response always shows the segment and anode drive currently held, plus a
// flag when a value or text request was dropped because a mode name is being
// held. The hold length register may be written at any time the block is idle.
module seven_segment_mux_display_formatter
   import sseg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   sseg_req_if.sink   req_ch,
   sseg_rsp_if.source rsp_ch,
   sseg_csr_if.sink   csr_ch
);

   item_type    item_ff;
   quot_type    quot_ff;
   logic        in_valid_ff;
   logic        out_valid_ff;
   logic        ignored_ff;
   logic        ignored_in;
   symbols_type buf_ff;
   symbols_type buf_in;
   logic [1:0]  scan_ff;
   logic [1:0]  scan_in;
   logic [11:0] hold_ff;
   logic [11:0] hold_in;
   logic [11:0] hold_ms_ff;
   logic [6:0]  seg_ff;
   logic [6:0]  seg_in;
   logic [3:0]  anode_ff;
   logic [3:0]  anode_in;
   logic [14:0] req_mag;
   quot_type    req_quot;
   logic        advance;
   logic        held;
   sym_type     d0, d1, d2, d3, d4;
   sym_type     scan_sym;

   // Second stage moves when its result can enter the response register.
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign csr_ch.ready = 1'b1;

   // Negative values count as zero.
   assign req_mag = req_ch.value[15] ? 15'd0 : req_ch.value[14:0];

   sseg_divide u_divide (
      .mag  (req_mag),
      .quot (req_quot)
   );

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
      if (req_ch.valid && req_ch.ready) begin
         item_ff.kind        <= req_ch.kind;
         item_ff.mag         <= req_mag;
         item_ff.work_screen <= req_ch.work_screen;
         item_ff.menu_item   <= req_ch.menu_item;
         item_ff.mode_number <= req_ch.mode_number;
         item_ff.text        <= {req_ch.text_char_3, req_ch.text_char_2,
                                 req_ch.text_char_1, req_ch.text_char_0};
         quot_ff             <= req_quot;
      end
   end

   // Decimal digits, units first.
   assign d0 = digit_of(item_ff.mag, quot_ff.q1);
   assign d1 = digit_of(15'(quot_ff.q1), 12'(quot_ff.q2));
   assign d2 = digit_of(15'(quot_ff.q2), 12'(quot_ff.q3));
   assign d3 = digit_of(15'(quot_ff.q3), 12'(quot_ff.q4));
   assign d4 = {3'b000, quot_ff.q4};

   assign held = hold_ff != 12'd0;

   // Symbol under the scanner; out-of-range codes show blank.
   assign scan_sym = (buf_ff[scan_ff] > SYM_MAX) ? SYM_BLANK : buf_ff[scan_ff];

   // Apply one request to the display state.
   always_comb begin
      logic ended;
      buf_in     = buf_ff;
      scan_in    = scan_ff;
      hold_in    = hold_ff;
      seg_in     = seg_ff;
      anode_in   = anode_ff;
      ignored_in = 1'b0;
      ended      = 1'b0;
      unique case (item_ff.kind)
         KIND_TICK: begin
            seg_in   = glyph(scan_sym);
            anode_in = 4'b0001 << scan_ff;
            scan_in  = scan_ff + 2'd1;
            if (held) begin
               hold_in = hold_ff - 12'd1;
            end
         end
         KIND_VALUE: begin
            if (held) begin
               ignored_in = 1'b1;
            end else if (item_ff.work_screen) begin
               // Amps: A, hundreds from 100, tens and units always.
               buf_in[0] = SYM_A;
               buf_in[1] = (quot_ff.q2 != 9'd0) ? d2 : SYM_BLANK;
               buf_in[2] = d1;
               buf_in[3] = d0;
            end else if (item_ff.menu_item == 4'd0 || item_ff.menu_item == 4'd2 ||
                         item_ff.menu_item == 4'd3 || item_ff.menu_item == 4'd4) begin
               // Seconds from milliseconds, shown with tenths.
               buf_in[0] = (quot_ff.q4 != 2'd0) ? d4 : SYM_BLANK;
               buf_in[1] = d3;
               buf_in[2] = SYM_SEP;
               buf_in[3] = d2;
            end else begin
               // Plain decimal with leading zeros blanked.
               buf_in[0] = (quot_ff.q3 != 6'd0) ? d3 : SYM_BLANK;
               buf_in[1] = (quot_ff.q2 != 9'd0) ? d2 : SYM_BLANK;
               buf_in[2] = (quot_ff.q1 != 12'd0) ? d1 : SYM_BLANK;
               buf_in[3] = d0;
            end
         end
         KIND_MODE: begin
            if (item_ff.mode_number < MODE_WORDS) begin
               buf_in = mode_word(item_ff.mode_number);
            end
            hold_in = hold_ms_ff;
         end
         KIND_TEXT: begin
            if (held) begin
               ignored_in = 1'b1;
            end else begin
               // A zero character blanks itself and everything after it.
               for (int i = 0; i < 4; i++) begin
                  if (item_ff.text[i] == 8'd0) begin
                     ended = 1'b1;
                  end
                  buf_in[i] = ended ? SYM_BLANK : char_symbol(item_ff.text[i]);
               end
            end
         end
         default: begin
            buf_in = buf_ff;
         end
      endcase
   end

   // Display state and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff       <= {SYM_BLANK, SYM_BLANK, SYM_BLANK, SYM_BLANK};
         scan_ff      <= 2'd0;
         hold_ff      <= 12'd0;
         seg_ff       <= SEG_DARK;
         anode_ff     <= 4'd0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            buf_ff       <= buf_in;
            scan_ff      <= scan_in;
            hold_ff      <= hold_in;
            seg_ff       <= seg_in;
            anode_ff     <= anode_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         ignored_ff <= ignored_in;
      end
   end

   // Hold length register.
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ms_ff <= HOLD_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         hold_ms_ff <= csr_ch.hold_ms;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.segments       = seg_ff;
   assign rsp_ch.anode_enable   = anode_ff;
   assign rsp_ch.update_ignored = ignored_ff;

endmodule
